@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dst_pkg.sv @@
package dst_pkg;

    localparam int unsigned DATA_W     = 64;
    localparam int unsigned ADDR_W     = 6;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register indexes, taken from paddr[5:3]
    localparam logic [2:0] REG_DELIM_LO     = 3'd0;
    localparam logic [2:0] REG_DELIM_MID_LO = 3'd1;
    localparam logic [2:0] REG_DELIM_MID_HI = 3'd2;
    localparam logic [2:0] REG_DELIM_HI     = 3'd3;
    localparam logic [2:0] REG_MAX_PARTS    = 3'd4;

    typedef struct packed {
        logic [255:0]         delim_mask;
        logic [COUNT_W-1:0]   max_parts;
    } cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    ch;
        logic                 last;
        logic                 is_delim;
    } cls_item_t;

endpackage

@@ hdl/dst_regs.sv @@
module dst_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dst_pkg::ADDR_W-1:0]    paddr,
    input  logic [dst_pkg::DATA_W-1:0]    pwdata,
    output logic [dst_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output dst_pkg::cfg_t                 cfg
);

    logic [63:0]                       delim_lo_reg;
    logic [63:0]                       delim_mid_lo_reg;
    logic [63:0]                       delim_mid_hi_reg;
    logic [63:0]                       delim_hi_reg;
    logic [dst_pkg::COUNT_W-1:0]       max_parts_reg;
    logic                              wr_en;
    logic [2:0]                        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_lo_reg     <= '0;
            delim_mid_lo_reg <= '0;
            delim_mid_hi_reg <= '0;
            delim_hi_reg     <= '0;
            max_parts_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                dst_pkg::REG_DELIM_LO:     delim_lo_reg     <= pwdata;
                dst_pkg::REG_DELIM_MID_LO: delim_mid_lo_reg <= pwdata;
                dst_pkg::REG_DELIM_MID_HI: delim_mid_hi_reg <= pwdata;
                dst_pkg::REG_DELIM_HI:     delim_hi_reg     <= pwdata;
                dst_pkg::REG_MAX_PARTS:    max_parts_reg    <= pwdata[dst_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            dst_pkg::REG_DELIM_LO:     prdata = delim_lo_reg;
            dst_pkg::REG_DELIM_MID_LO: prdata = delim_mid_lo_reg;
            dst_pkg::REG_DELIM_MID_HI: prdata = delim_mid_hi_reg;
            dst_pkg::REG_DELIM_HI:     prdata = delim_hi_reg;
            dst_pkg::REG_MAX_PARTS:
                prdata = {{(dst_pkg::DATA_W-dst_pkg::COUNT_W){1'b0}}, max_parts_reg};
            default:                   prdata = '0;
        endcase
    end

    assign cfg.delim_mask = {delim_hi_reg, delim_mid_hi_reg, delim_mid_lo_reg, delim_lo_reg};
    assign cfg.max_parts  = max_parts_reg;

endmodule

@@ hdl/dst_front.sv @@
module dst_front
(
    input  logic                          push,
    output logic                          full,
    input  logic [dst_pkg::CHAR_W-1:0]    char_in,
    input  logic                          string_last,
    input  dst_pkg::cfg_t                 cfg,
    input  logic                          q_full,
    output logic                          q_wr,
    output dst_pkg::cls_item_t            q_data
);

    // Accept while the queue has room; classify against the delimiter bitmap.
    assign full            = q_full;
    assign q_wr            = push && !q_full;
    assign q_data.ch       = char_in;
    assign q_data.last     = string_last;
    assign q_data.is_delim = cfg.delim_mask[char_in];

endmodule

@@ hdl/dst_fifo.sv @@
`include "assert_macros.svh"

module dst_fifo
#(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = dst_pkg::FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "fifo count overflow")
    `ASSERT_NEXT(a_count_grow, clk, rst_n, do_wr && !do_rd, count_reg == $past(count_reg) + 1'b1, "fifo count did not grow on write")

endmodule

@@ hdl/dst_back.sv @@
`include "assert_macros.svh"

module dst_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dst_pkg::cfg_t                 cfg,
    input  logic                          q_empty,
    input  dst_pkg::cls_item_t            q_data,
    output logic                          q_rd,
    input  logic                          pop,
    output logic                          empty,
    output logic [dst_pkg::CHAR_W-1:0]    char_out,
    output logic                          kept,
    output logic [dst_pkg::COUNT_W-1:0]   token_number,
    output logic                          token_first,
    output logic                          prior_token_ended,
    output logic                          string_end,
    output logic [dst_pkg::COUNT_W-1:0]   token_total
);

    logic                          inside_token_reg, inside_token_next;
    logic                          remainder_mode_reg, remainder_mode_next;
    logic [dst_pkg::COUNT_W-1:0]   tokens_done_reg, tokens_done_next;
    logic                          count_over_reg, count_over_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          take;
    logic                          kept_next, first_next, ended_next;
    logic [dst_pkg::COUNT_W-1:0]   number_next, total_next, running_number;

    assign take  = !q_empty && (!out_valid_reg || pop);
    assign q_rd  = take;
    assign empty = !out_valid_reg;

    assign running_number = count_over_reg ? dst_pkg::COUNT_MAX : tokens_done_reg - 1'b1;

    always_comb
    begin
        inside_token_next   = inside_token_reg;
        remainder_mode_next = remainder_mode_reg;
        tokens_done_next    = tokens_done_reg;
        count_over_next     = count_over_reg;
        kept_next           = 1'b0;
        first_next          = 1'b0;
        ended_next          = 1'b0;
        number_next         = '0;
        total_next          = '0;

        if (remainder_mode_reg)
        begin
            kept_next   = 1'b1;
            number_next = running_number;
        end
        else if (q_data.is_delim)
        begin
            ended_next        = inside_token_reg;
            inside_token_next = 1'b0;
        end
        else if (inside_token_reg)
        begin
            kept_next   = 1'b1;
            number_next = running_number;
        end
        else
        begin
            kept_next   = 1'b1;
            first_next  = 1'b1;
            number_next = tokens_done_reg;
            if (tokens_done_reg != dst_pkg::COUNT_MAX)
            begin
                tokens_done_next = tokens_done_reg + 1'b1;
            end
            else
            begin
                count_over_next = 1'b1;
            end
            if ((cfg.max_parts != '0) && !count_over_next &&
                (tokens_done_reg == cfg.max_parts - 1'b1))
            begin
                remainder_mode_next = 1'b1;
            end
            inside_token_next = 1'b1;
        end

        if (q_data.last)
        begin
            total_next          = tokens_done_next;
            inside_token_next   = 1'b0;
            remainder_mode_next = 1'b0;
            tokens_done_next    = '0;
            count_over_next     = 1'b0;
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_token_reg   <= 1'b0;
            remainder_mode_reg <= 1'b0;
            tokens_done_reg    <= '0;
            count_over_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                inside_token_reg   <= inside_token_next;
                remainder_mode_reg <= remainder_mode_next;
                tokens_done_reg    <= tokens_done_next;
                count_over_reg     <= count_over_next;
            end
        end
    end

    // Hold the result register until a new item replaces it.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_out          <= q_data.ch;
            kept              <= kept_next;
            token_number      <= number_next;
            token_first       <= first_next;
            prior_token_ended <= ended_next;
            string_end        <= q_data.last;
            token_total       <= total_next;
        end
    end

    `ASSERT_ALWAYS(a_remainder_in_token, clk, rst_n, !remainder_mode_reg || inside_token_reg, "remainder mode outside a token")
    `ASSERT_ALWAYS(a_over_saturated, clk, rst_n, !count_over_reg || (tokens_done_reg == dst_pkg::COUNT_MAX), "count over without saturated counter")

endmodule

@@ hdl/delimiter_set_tokenizer.sv @@
// Delimiter-set tokenizer. Bytes of a string enter through a queue-style
// push/full port, the last byte flagged by string_last, and one result per
// byte leaves through an empty/pop port in the same order. A byte whose bit
// is set in the 256-bit delimiter bitmap (four 64-bit registers at byte
// addresses 0, 8, 16 and 24) is dropped between tokens; non-empty runs of
// other bytes are tokens, numbered from zero. With max_parts (address 32)
// nonzero, the token that reaches number max_parts-1 keeps every byte up to
// string end, delimiters included. Token counts saturate at 65535, and all
// token state clears after the final byte. Write registers only while the
// block is idle. Throughput is one byte per clock while the result side is
// not stalled, and the back part updates its token state as each byte is
// taken; an accepted byte passes through the queue and then the result
// register before it reaches the result ports. A short queue decouples the
// classifying front part from the back part.
module delimiter_set_tokenizer
#(
    parameter int unsigned FIFO_DEPTH = dst_pkg::FIFO_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dst_pkg::ADDR_W-1:0]    paddr,
    input  logic [dst_pkg::DATA_W-1:0]    pwdata,
    output logic [dst_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input bytes
    input  logic                          push,
    output logic                          full,
    input  logic [dst_pkg::CHAR_W-1:0]    char_in,
    input  logic                          string_last,
    // results
    input  logic                          pop,
    output logic                          empty,
    output logic [dst_pkg::CHAR_W-1:0]    char_out,
    output logic                          kept,
    output logic [dst_pkg::COUNT_W-1:0]   token_number,
    output logic                          token_first,
    output logic                          prior_token_ended,
    output logic                          string_end,
    output logic [dst_pkg::COUNT_W-1:0]   token_total
);

    dst_pkg::cfg_t         cfg;
    dst_pkg::cls_item_t    front_item;
    dst_pkg::cls_item_t    back_item;
    logic                  q_wr;
    logic                  q_rd;
    logic                  q_full;
    logic                  q_empty;

    // Register file: decode each write transaction, return reads.
    dst_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: accept the input transaction and tag the byte as delimiter or not.
    dst_front u_front
    (
        .push        (push),
        .full        (full),
        .char_in     (char_in),
        .string_last (string_last),
        .cfg         (cfg),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_data      (front_item)
    );

    // Queue: hold classified bytes while the back part is stalled.
    dst_fifo
    #(
        .WIDTH ($bits(dst_pkg::cls_item_t)),
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (front_item),
        .rd_en   (q_rd),
        .rd_data (back_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: advance the token state and hold each result until popped.
    dst_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .q_empty           (q_empty),
        .q_data            (back_item),
        .q_rd              (q_rd),
        .pop               (pop),
        .empty             (empty),
        .char_out          (char_out),
        .kept              (kept),
        .token_number      (token_number),
        .token_first       (token_first),
        .prior_token_ended (prior_token_ended),
        .string_end        (string_end),
        .token_total       (token_total)
    );

endmodule
